// ----- sv/tlrp_pkg.sv -----
// Shared constants, types and codes for the two-level LRU refresh predictor.
// No dependencies; every other file but the RAM and the bench channel file imports this package.
`default_nettype none

package tlrp_pkg;

  localparam int ENTRIES    = 1024;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int TAG_BITS   = 48;
  localparam int TIME_BITS  = 40;
  localparam int CTR_W      = 48;
  localparam int RET_W      = 40;
  localparam int CAP_W      = 11;
  localparam int REF_W      = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [RET_W-1:0] RET_RESET = RET_W'(300000000);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1000);

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] CFG_RETENTION = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = CFG_IDX_W'(1);

  // List selectors.
  localparam logic LIST_PROB = 1'b0;
  localparam logic LIST_PROT = 1'b1;

  typedef enum logic [1:0] {
    OUT_WITHIN  = 2'd0,
    OUT_BEYOND  = 2'd1,
    OUT_PROMOTE = 2'd2,
    OUT_MISS    = 2'd3
  } outcome_e;

  // One slot of a list memory.
  typedef struct packed {
    logic                 valid;
    logic [TAG_BITS-1:0]  tag;
    logic [TIME_BITS-1:0] stamp;
    logic [IDX_W-1:0]     prv;
    logic [IDX_W-1:0]     nxt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_UP,
    ST_UP_WR,
    ST_UN,
    ST_UN_WR,
    ST_INV,
    ST_PUSH,
    ST_PH_WR,
    ST_FIN
  } state_e;

endpackage

`default_nettype wire

// ----- sv/tlrp_if.sv -----
// Channel interfaces of the predictor: request, result and configuration write.
// Depends on tlrp_pkg for field widths and the outcome type.
`default_nettype none

interface tlrp_req_if;
  import tlrp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] timestamp;
  logic [TAG_BITS-1:0]  block_number;
  modport source (output valid, output timestamp, output block_number, input ready);
  modport sink   (input valid, input timestamp, input block_number, output ready);
endinterface

interface tlrp_rsp_if;
  import tlrp_pkg::*;
  logic             valid;
  logic             ready;
  outcome_e         outcome;
  logic [REF_W-1:0] refresh_added;
  logic [CTR_W-1:0] hit_total;
  logic [CTR_W-1:0] within_total;
  logic [CTR_W-1:0] beyond_total;
  logic [CTR_W-1:0] refresh_total;
  logic [CTR_W-1:0] promote_total;
  modport source (output valid, output outcome, output refresh_added, output hit_total,
                  output within_total, output beyond_total, output refresh_total,
                  output promote_total, input ready);
  modport sink   (input valid, input outcome, input refresh_added, input hit_total,
                  input within_total, input beyond_total, input refresh_total,
                  input promote_total, output ready);
endinterface

interface tlrp_cfg_if;
  import tlrp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/tlrp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tlrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- sv/tlrp_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle, for the refresh charge.
// Depends on tlrp_pkg for the operand width.
`default_nettype none

module tlrp_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [tlrp_pkg::RET_W-1:0] dividend_i,
  input  logic [tlrp_pkg::RET_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic [tlrp_pkg::RET_W-1:0] quotient_o
);
  import tlrp_pkg::*;

  localparam int STEP_W = $clog2(RET_W + 1);

  logic [RET_W-1:0]  rem_q;
  logic [RET_W-1:0]  quo_q;
  logic [RET_W-1:0]  dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic [RET_W:0]    rem_sh;
  logic [RET_W:0]    rem_sub;
  logic              take;

  assign rem_sh  = {rem_q, quo_q[RET_W-1]};
  assign take    = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(RET_W);
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so the top bit drops cleanly.
      rem_q <= take ? rem_sub[RET_W-1:0] : rem_sh[RET_W-1:0];
      quo_q <= {quo_q[RET_W-2:0], take};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ----- sv/two_level_lru_refresh_predictor_unit.sv -----
// Top level of the two-level LRU refresh predictor: sequencer and list memories.
// Depends on tlrp_pkg, tlrp_if, tlrp_ram and tlrp_div.
//
//   port    direction  contents
//   req_i   in         timestamp, block_number
//   rsp_o   out        outcome, refresh_added and five running totals
//   cfg_i   in         index, data (retention_ticks, capacity_in_use)
//
// After reset a clearing pass writes every slot of both list memories, during which
// no request is taken; configuration writes are taken at any time.
// An access runs through the tag scan, which reads one slot of each list memory per
// cycle, and the decision, then through list relinking and the loading of the
// result. A promotion that evicts from the protected list also waits for the divider.
// A result waits in the output register; the next request is taken meanwhile.
`default_nettype none

module two_level_lru_refresh_predictor_unit (
  input  logic clk_i,
  input  logic rst_ni,
  tlrp_req_if.sink   req_i,
  tlrp_rsp_if.source rsp_o,
  tlrp_cfg_if.sink   cfg_i
);
  import tlrp_pkg::*;

  state_e state_q, state_d;

  logic [IDX_W-1:0] scan_q;
  logic             chk_v_q;
  logic [IDX_W-1:0] chk_idx_q;

  logic [TIME_BITS-1:0] t_q;
  logic [TAG_BITS-1:0]  tag_q;

  // Scan results, one per list.
  logic [1:0]             hit_q;
  logic [1:0][IDX_W-1:0]  hit_idx_q;
  logic [1:0][IDX_W-1:0]  hit_p_q;
  logic [1:0][IDX_W-1:0]  hit_n_q;
  logic [TIME_BITS-1:0]   hit_time_q;
  logic [1:0]             free_v_q;
  logic [1:0][IDX_W-1:0]  free_idx_q;
  entry_t [1:0]           tail_w_q;

  logic [1:0][IDX_W-1:0] head_q;
  logic [1:0][IDX_W-1:0] tail_q;
  logic [1:0][CNT_W-1:0] count_q;

  logic             cur_q;
  logic             push_list_q;
  logic             second_q;
  logic             push_ok_q;
  logic             div_pend_q;
  logic [IDX_W-1:0] op_idx_q;
  logic [IDX_W-1:0] op_p_q;
  logic [IDX_W-1:0] op_n_q;
  logic [IDX_W-1:0] slot_q;
  outcome_e         outcome_q;

  logic [RET_W-1:0] ret_q;
  logic [CAP_W-1:0] cap_q;

  logic [CTR_W-1:0] hits_q, within_q, beyond_q, refresh_q, promo_q;

  logic             out_valid_q;
  outcome_e         out_outcome_q;
  logic [REF_W-1:0] out_added_q;
  logic [CTR_W-1:0] out_hits_q, out_within_q, out_beyond_q, out_refresh_q, out_promo_q;

  logic [1:0]       ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  entry_t [1:0]     ram_rd;
  entry_t           cur_rd;

  logic             div_start;
  logic             div_busy;
  logic [RET_W-1:0] div_quo;
  logic             out_load;
  logic             req_acc;

  // Decision values.
  logic [CNT_W-1:0]     cap_eff;
  logic [1:0]           evict;
  logic [TIME_BITS-1:0] gap;
  logic                 in_ret;
  logic [TIME_BITS-1:0] age;
  logic [RET_W-1:0]     divisor;
  logic                 tgt;
  logic                 freed_v;
  logic [IDX_W-1:0]     freed_idx;
  logic [IDX_W-1:0]     slot_w;
  logic                 push_ok_w;
  logic [REF_W-1:0]     added_w;
  logic [CTR_W-1:0]     refresh_sum;

  logic [1:0] scan_match;
  logic [1:0] scan_free;
  logic [1:0] scan_tail;

  assign req_acc      = req_i.valid && req_i.ready;
  assign req_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign cur_rd       = ram_rd[cur_q];

  tlrp_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_prob_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we[LIST_PROB]),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rd[LIST_PROB])
  );

  tlrp_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_prot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we[LIST_PROT]),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rd[LIST_PROT])
  );

  tlrp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (age),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  // Scan compare on the slot read in the previous cycle.
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      scan_match[l] = chk_v_q && ram_rd[l].valid && (ram_rd[l].tag == tag_q);
      scan_free[l]  = chk_v_q && !ram_rd[l].valid;
      scan_tail[l]  = chk_v_q && (chk_idx_q == tail_q[l]);
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(cap_q) > ENTRIES) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end
    for (int l = 0; l < 2; l++) begin
      evict[l] = (count_q[l] != '0) && (count_q[l] >= cap_eff);
    end
    gap     = (t_q > hit_time_q) ? t_q - hit_time_q : '0;
    in_ret  = gap < ret_q;
    age     = (t_q > tail_w_q[LIST_PROT].stamp) ? t_q - tail_w_q[LIST_PROT].stamp : '0;
    divisor = (ret_q == '0) ? RET_W'(1) : ret_q;

    if (hit_q[LIST_PROT]) begin
      tgt       = LIST_PROT;
      freed_v   = 1'b1;
      freed_idx = hit_idx_q[LIST_PROT];
    end else if (hit_q[LIST_PROB]) begin
      tgt       = LIST_PROT;
      freed_v   = evict[LIST_PROT];
      freed_idx = tail_q[LIST_PROT];
    end else begin
      tgt       = LIST_PROB;
      freed_v   = evict[LIST_PROB];
      freed_idx = tail_q[LIST_PROB];
    end
    // The new entry takes the lowest free slot, counting the one just freed.
    if (freed_v && !(free_v_q[tgt] && (free_idx_q[tgt] < freed_idx))) begin
      slot_w = freed_idx;
    end else begin
      slot_w = free_idx_q[tgt];
    end
    push_ok_w = free_v_q[tgt] || freed_v;

    added_w     = div_pend_q ? div_quo[REF_W-1:0] : '0;
    refresh_sum = refresh_q + CTR_W'(added_w);
  end

  // Sequencer.
  always_comb begin
    entry_t w;
    w         = cur_rd;
    state_d   = state_q;
    ram_we    = '0;
    ram_waddr = op_idx_q;
    ram_wdata = '0;
    ram_raddr = scan_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 2'b11;
        ram_waddr = scan_q;
        if (scan_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_q == LAST_IDX) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (hit_q[LIST_PROT]) begin
          state_d = ST_UP;
        end else if (hit_q[LIST_PROB]) begin
          state_d   = ST_UP;
          div_start = evict[LIST_PROT];
        end else if (evict[LIST_PROB]) begin
          state_d = ST_UP;
        end else begin
          state_d = push_ok_w ? ST_PUSH : ST_FIN;
        end
      end
      ST_UP: begin
        if (op_idx_q != head_q[cur_q]) begin
          ram_raddr = op_p_q;
          state_d   = ST_UP_WR;
        end else begin
          state_d = ST_UN;
        end
      end
      ST_UP_WR: begin
        w.nxt          = op_n_q;
        ram_we[cur_q]  = 1'b1;
        ram_waddr      = op_p_q;
        ram_wdata      = w;
        state_d        = ST_UN;
      end
      ST_UN: begin
        if (op_idx_q != tail_q[cur_q]) begin
          ram_raddr = op_n_q;
          state_d   = ST_UN_WR;
        end else begin
          state_d = ST_INV;
        end
      end
      ST_UN_WR: begin
        w.prv          = op_p_q;
        ram_we[cur_q]  = 1'b1;
        ram_waddr      = op_n_q;
        ram_wdata      = w;
        state_d        = ST_INV;
      end
      ST_INV: begin
        ram_we[cur_q] = 1'b1;
        ram_waddr     = op_idx_q;
        if (second_q) begin
          state_d = ST_UP;
        end else begin
          state_d = push_ok_q ? ST_PUSH : ST_FIN;
        end
      end
      ST_PUSH: begin
        w.valid       = 1'b1;
        w.tag         = tag_q;
        w.stamp       = t_q;
        w.prv         = slot_q;
        w.nxt         = (count_q[cur_q] == '0) ? slot_q : head_q[cur_q];
        ram_we[cur_q] = 1'b1;
        ram_waddr     = slot_q;
        ram_wdata     = w;
        if (count_q[cur_q] != '0) begin
          ram_raddr = head_q[cur_q];
          state_d   = ST_PH_WR;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_PH_WR: begin
        w.prv          = slot_q;
        ram_we[cur_q]  = 1'b1;
        ram_waddr      = head_q[cur_q];
        ram_wdata      = w;
        state_d        = ST_FIN;
      end
      ST_FIN: begin
        if (!div_busy && (!out_valid_q || rsp_o.ready)) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      scan_q      <= '0;
      chk_v_q     <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      cur_q       <= LIST_PROB;
      push_list_q <= LIST_PROB;
      second_q    <= 1'b0;
      push_ok_q   <= 1'b0;
      div_pend_q  <= 1'b0;
      ret_q       <= RET_RESET;
      cap_q       <= CAP_RESET;
      hits_q      <= '0;
      within_q    <= '0;
      beyond_q    <= '0;
      refresh_q   <= '0;
      promo_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      chk_v_q <= (state_q == ST_SCAN);

      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          CFG_RETENTION: ret_q <= cfg_i.data[RET_W-1:0];
          CFG_CAPACITY:  cap_q <= cfg_i.data[CAP_W-1:0];
          default: ;
        endcase
      end

      if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
        scan_q <= scan_q + IDX_W'(1);
      end else if (req_acc) begin
        scan_q <= '0;
      end

      if (state_q == ST_DECIDE) begin
        push_ok_q <= push_ok_w;
        if (hit_q[LIST_PROT]) begin
          cur_q       <= LIST_PROT;
          push_list_q <= LIST_PROT;
          second_q    <= 1'b0;
          div_pend_q  <= 1'b0;
          hits_q      <= hits_q + CTR_W'(1);
          if (in_ret) begin
            within_q <= within_q + CTR_W'(1);
          end else begin
            beyond_q <= beyond_q + CTR_W'(1);
          end
        end else if (hit_q[LIST_PROB]) begin
          cur_q       <= LIST_PROB;
          push_list_q <= LIST_PROT;
          second_q    <= evict[LIST_PROT];
          div_pend_q  <= evict[LIST_PROT];
          promo_q     <= promo_q + CTR_W'(1);
        end else begin
          cur_q       <= LIST_PROB;
          push_list_q <= LIST_PROB;
          second_q    <= 1'b0;
          div_pend_q  <= 1'b0;
        end
      end

      if (state_q == ST_INV) begin
        if (op_idx_q == head_q[cur_q]) begin
          head_q[cur_q] <= op_n_q;
        end
        if (op_idx_q == tail_q[cur_q]) begin
          tail_q[cur_q] <= op_p_q;
        end
        count_q[cur_q] <= count_q[cur_q] - CNT_W'(1);
        // A promotion continues with the eviction from the protected list.
        cur_q    <= second_q ? LIST_PROT : push_list_q;
        second_q <= 1'b0;
      end

      if (state_q == ST_PUSH) begin
        count_q[cur_q] <= count_q[cur_q] + CNT_W'(1);
        if (count_q[cur_q] == '0) begin
          head_q[cur_q] <= slot_q;
          tail_q[cur_q] <= slot_q;
        end
      end

      if (state_q == ST_PH_WR) begin
        head_q[cur_q] <= slot_q;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
        refresh_q   <= refresh_sum;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= scan_q;

    if (req_acc) begin
      t_q      <= req_i.timestamp;
      tag_q    <= req_i.block_number;
      hit_q    <= '0;
      free_v_q <= '0;
    end

    for (int l = 0; l < 2; l++) begin
      if (scan_match[l]) begin
        hit_q[l]     <= 1'b1;
        hit_idx_q[l] <= chk_idx_q;
        hit_p_q[l]   <= ram_rd[l].prv;
        hit_n_q[l]   <= ram_rd[l].nxt;
        if (l == int'(LIST_PROT)) begin
          hit_time_q <= ram_rd[l].stamp;
        end
      end
      if (scan_free[l] && !free_v_q[l]) begin
        free_v_q[l]   <= 1'b1;
        free_idx_q[l] <= chk_idx_q;
      end
      if (scan_tail[l]) begin
        tail_w_q[l] <= ram_rd[l];
      end
    end

    if (state_q == ST_DECIDE) begin
      slot_q <= slot_w;
      if (hit_q[LIST_PROT]) begin
        op_idx_q  <= hit_idx_q[LIST_PROT];
        op_p_q    <= hit_p_q[LIST_PROT];
        op_n_q    <= hit_n_q[LIST_PROT];
        outcome_q <= in_ret ? OUT_WITHIN : OUT_BEYOND;
      end else if (hit_q[LIST_PROB]) begin
        op_idx_q  <= hit_idx_q[LIST_PROB];
        op_p_q    <= hit_p_q[LIST_PROB];
        op_n_q    <= hit_n_q[LIST_PROB];
        outcome_q <= OUT_PROMOTE;
      end else begin
        op_idx_q  <= tail_q[LIST_PROB];
        op_p_q    <= tail_w_q[LIST_PROB].prv;
        op_n_q    <= tail_w_q[LIST_PROB].nxt;
        outcome_q <= OUT_MISS;
      end
    end

    if (state_q == ST_INV && second_q) begin
      op_idx_q <= tail_q[LIST_PROT];
      op_p_q   <= tail_w_q[LIST_PROT].prv;
      op_n_q   <= tail_w_q[LIST_PROT].nxt;
    end

    if (out_load) begin
      out_outcome_q <= outcome_q;
      out_added_q   <= added_w;
      out_hits_q    <= hits_q;
      out_within_q  <= within_q;
      out_beyond_q  <= beyond_q;
      out_refresh_q <= refresh_sum;
      out_promo_q   <= promo_q;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.outcome       = out_outcome_q;
  assign rsp_o.refresh_added = out_added_q;
  assign rsp_o.hit_total     = out_hits_q;
  assign rsp_o.within_total  = out_within_q;
  assign rsp_o.beyond_total  = out_beyond_q;
  assign rsp_o.refresh_total = out_refresh_q;
  assign rsp_o.promote_total = out_promo_q;

  // A list never holds more entries than there are slots.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q[LIST_PROB] <= CNT_W'(ENTRIES)) && (count_q[LIST_PROT] <= CNT_W'(ENTRIES)))
    else $error("list count exceeds the number of slots");

  // Unlinking always removes a member of a nonempty list.
  a_unlink_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INV) |-> (count_q[cur_q] != '0))
    else $error("unlink from an empty list");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> (state_q == ST_SCAN) && (scan_q == '0))
    else $error("accepted request did not start a scan");

  a_fin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && state_d == ST_IDLE) |=> out_valid_q)
    else $error("finished access produced no result");

endmodule

`default_nettype wire

// ----- bench/tlrp_bench_if.sv -----
// Testbench-side channel definitions: none beyond the block's own interfaces.
// The bench uses the channel interfaces declared in the RTL tlrp_if file.
`timescale 1ns / 100ps

// ----- bench/tlrp_checker.sv -----
// Checker for the two-level LRU refresh predictor: predicts each result and compares.
// Depends on tlrp_pkg and the channel interfaces in tlrp_if.
`timescale 1ns / 100ps

module tlrp_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tlrp_req_if.sink  req,
  tlrp_rsp_if.sink  rsp,
  tlrp_cfg_if.sink  cfg,
  output int        fail_count,
  output int        pending_count
);
  import tlrp_pkg::*;

  typedef struct {
    outcome_e          outcome;
    logic [REF_W-1:0]  refresh_added;
    logic [CTR_W-1:0]  hit_total, within_total, beyond_total, refresh_total, promote_total;
  } access_result_t;

  // Each list is kept in MRU-first order.
  typedef struct {
    logic [TAG_BITS-1:0]  tag;
    logic [TIME_BITS-1:0] stamp;
  } slot_t;

  slot_t prob_list[$];
  slot_t prot_list[$];
  access_result_t expected_results[$];
  logic [RET_W-1:0] retention;
  logic [CAP_W-1:0] capacity;
  logic [CTR_W-1:0] hits, withins, beyonds, refreshes, promotions;

  assign pending_count = expected_results.size();

  function automatic logic [TIME_BITS-1:0] age(logic [TIME_BITS-1:0] now,
                                               logic [TIME_BITS-1:0] then_t);
    return (now > then_t) ? now - then_t : '0;
  endfunction

  function automatic int cap_limit();
    if (capacity == 0) return 1;
    if (capacity > ENTRIES) return ENTRIES;
    return capacity;
  endfunction

  function automatic int find_tag(ref slot_t l[$], logic [TAG_BITS-1:0] tag);
    foreach (l[i]) if (l[i].tag == tag) return i;
    return -1;
  endfunction

  task automatic predict_access(logic [TIME_BITS-1:0] ts, logic [TAG_BITS-1:0] tag);
    access_result_t r;
    slot_t s;
    int i;
    logic [RET_W-1:0] div;
    logic [TIME_BITS-1:0] added;
    added = '0;
    s.tag = tag;
    s.stamp = ts;
    i = find_tag(prot_list, tag);
    if (i >= 0) begin
      if (age(ts, prot_list[i].stamp) < retention) begin
        withins++;
        r.outcome = OUT_WITHIN;
      end else begin
        beyonds++;
        r.outcome = OUT_BEYOND;
      end
      prot_list.delete(i);
      prot_list.insert(0, s);
      hits++;
    end else begin
      i = find_tag(prob_list, tag);
      if (i >= 0) begin
        prob_list.delete(i);
        div = (retention == 0) ? 1 : retention;
        if (prot_list.size() > 0 && prot_list.size() >= cap_limit()) begin
          added = age(ts, prot_list[$].stamp) / div;
          prot_list.delete(prot_list.size() - 1);
        end
        prot_list.insert(0, s);
        refreshes += CTR_W'(added);
        promotions++;
        r.outcome = OUT_PROMOTE;
      end else begin
        if (prob_list.size() > 0 && prob_list.size() >= cap_limit())
          prob_list.delete(prob_list.size() - 1);
        prob_list.insert(0, s);
        r.outcome = OUT_MISS;
      end
    end
    r.refresh_added = added;
    r.hit_total = hits;
    r.within_total = withins;
    r.beyond_total = beyonds;
    r.refresh_total = refreshes;
    r.promote_total = promotions;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    access_result_t e;
    if (!rst_ni) begin
      prob_list.delete();
      prot_list.delete();
      expected_results.delete();
      retention <= RET_RESET;
      capacity <= CAP_RESET;
      hits = '0; withins = '0; beyonds = '0; refreshes = '0; promotions = '0;
      fail_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_RETENTION) retention <= RET_W'(cfg.data);
        else if (cfg.index == CFG_CAPACITY) capacity <= CAP_W'(cfg.data);
      end
      if (req.valid && req.ready) predict_access(req.timestamp, req.block_number);
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result transaction", 0, 0);
        end else begin
          e = expected_results.pop_front();
          if (rsp.outcome != e.outcome) report("outcome", rsp.outcome, e.outcome);
          if (rsp.refresh_added != e.refresh_added)
            report("refresh_added", rsp.refresh_added, e.refresh_added);
          if (rsp.hit_total != e.hit_total) report("hit_total", rsp.hit_total, e.hit_total);
          if (rsp.within_total != e.within_total)
            report("within_total", rsp.within_total, e.within_total);
          if (rsp.beyond_total != e.beyond_total)
            report("beyond_total", rsp.beyond_total, e.beyond_total);
          if (rsp.refresh_total != e.refresh_total)
            report("refresh_total", rsp.refresh_total, e.refresh_total);
          if (rsp.promote_total != e.promote_total)
            report("promote_total", rsp.promote_total, e.promote_total);
        end
      end
    end
  end

endmodule

// ----- bench/tb.sv -----
// Top of the predictor testbench: clock, reset, stimulus, stalls and verdict.
// Depends on tlrp_pkg, tlrp_if, tlrp_checker and the block itself.
`timescale 1ns / 100ps

module tb;
  import tlrp_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending_count;
  int   idle_cycles;
  bit   calm, hold_off;
  logic [TIME_BITS-1:0] now_ticks;
  logic [TAG_BITS-1:0]  recent_tags[$];

  tlrp_req_if req_ch();
  tlrp_rsp_if rsp_ch();
  tlrp_cfg_if cfg_ch();

  two_level_lru_refresh_predictor_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_ch.sink), .rsp_o(rsp_ch.source),
    .cfg_i(cfg_ch.sink)
  );

  tlrp_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .req(req_ch.sink), .rsp(rsp_ch.sink),
    .cfg(cfg_ch.sink), .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off.
  always @(posedge clk_i) begin
    if (hold_off) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("two_level_lru_refresh_predictor_unit: mismatch");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_access(logic [TIME_BITS-1:0] ts, logic [TAG_BITS-1:0] tag);
    while (!calm && $urandom_range(99) < 27) @(posedge clk_i);
    req_ch.valid <= 1'b1;
    req_ch.timestamp <= ts;
    req_ch.block_number <= tag;
    recent_tags.insert(recent_tags.size(), tag);
    if (recent_tags.size() > 12) void'(recent_tags.pop_front());
    do @(posedge clk_i); while (!req_ch.ready);
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_count != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
  endtask

  // Timestamp moves forward by a random step, now and then backwards.
  task automatic random_access();
    logic [TAG_BITS-1:0] tag;
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) now_ticks = TIME_BITS'({$urandom, $urandom});
    else now_ticks = now_ticks + $urandom_range(1200);
    if (pick < 70 && recent_tags.size() > 0)
      tag = recent_tags[$urandom_range(recent_tags.size() - 1)];
    else if (pick < 85) tag = TAG_BITS'($urandom_range(15));
    else tag = TAG_BITS'({$urandom, $urandom});
    send_access(now_ticks, tag);
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.timestamp = '0;
    req_ch.block_number = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_RETENTION;
    cfg_ch.data = '0;
    calm = 1'b0;
    hold_off = 1'b0;
    now_ticks = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a small list so evictions come early.
    write_reg(CFG_CAPACITY, 2);
    write_reg(CFG_RETENTION, 100);
    send_access(0, '0);
    send_access(10, '0);                    // promotion
    send_access(50, '0);                    // protected hit within retention
    send_access(150, '0);                   // exactly at retention: beyond
    send_access(20, '1);                    // time going backwards
    send_access(30, '1);
    send_access(40, 48'h5);
    send_access(45, 48'h5);                 // protected full: eviction
    send_access(TIME_BITS'('1), 48'h7);
    send_access(TIME_BITS'('1), 48'h7);     // large age charged
    send_access(TIME_BITS'('1), 48'h8);
    send_access(TIME_BITS'('1), 48'h9);
    send_access(TIME_BITS'('1), 48'ha);     // probation drop
    drain();
    write_reg(CFG_RETENTION, 0);            // zero retention acts as one
    write_reg(CFG_CAPACITY, 0);             // zero capacity acts as one
    send_access(5, 48'h1);
    send_access(6, 48'h1);
    send_access(7, 48'h2);
    send_access(900, 48'h2);
    drain();
    write_reg(CFG_RETENTION, {CFG_DATA_W{1'b1}});
    write_reg(CFG_CAPACITY, 11'h7ff);       // above the table size
    send_access(1000, 48'h1);
    send_access(2000, 48'h1);

    // Long hold-off while requests keep coming.
    fork
      begin
        hold_off = 1'b1;
        repeat (6000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      repeat (8) random_access();
    join

    drain();
    write_reg(CFG_CAPACITY, 4);
    write_reg(CFG_RETENTION, 500);
    repeat (100) random_access();
    calm = 1'b1;
    repeat (40) random_access();
    calm = 1'b0;
    drain();
    write_reg(CFG_CAPACITY, 1);
    write_reg(CFG_RETENTION, 1);
    repeat (50) random_access();
    drain();
    write_reg(CFG_CAPACITY, 8);
    write_reg(CFG_RETENTION, {$urandom_range(3000)});
    repeat (60) random_access();
    drain();

    if (fail_count == 0)
      $display("two_level_lru_refresh_predictor_unit: match");
    else
      $display("two_level_lru_refresh_predictor_unit: mismatch");
    $finish;
  end

endmodule
